[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the median filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("median filter assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("median filter assertion failed");

`endif

[hw/rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Constants, types and helpers shared by the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_BITS  = 32;
	localparam int CFG_W        = 7;
	localparam int WINDOW_RESET = 3;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int SUM_W = SAMPLE_BITS + 1;

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic [CNT_W-1:0]              cnt_t;
	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic [CFG_W-1:0]              cfg_t;

	// per-cycle command broadcast along the cell row
	typedef struct packed {
		logic en;    // apply one update this cycle
		logic full;  // window full: the oldest sample leaves
		logic up;    // insert below the removal point (cells shift up)
		smp_t smp;   // incoming sample
		smp_t old;   // sample leaving the window
	} swm_upd_t;

	// window length in use for a register value: zero reads as one,
	// values above the cell count saturate
	function automatic cnt_t eff_window(cfg_t ws);
		cnt_t k;
		if (ws == '0) begin
			k = CNT_W'(1);
		end else if (int'(ws) > MAX_WINDOW) begin
			k = CNT_W'(MAX_WINDOW);
		end else begin
			k = CNT_W'(ws);
		end
		return k;
	endfunction

endpackage

[hw/rtl/swm_if.sv]
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for input samples and median results.
// ----------------------------------------------------------------------------
interface swm_in_if;
	import swm_pkg::*;

	logic valid;
	logic ready;
	logic frame_start;
	smp_t sample;

	modport source (output valid, output frame_start, output sample, input ready);
	modport sink (input valid, input frame_start, input sample, output ready);
endinterface

interface swm_out_if;
	import swm_pkg::*;

	logic valid;
	logic ready;
	sum_t median_doubled;

	modport source (output valid, output median_doubled, input ready);
	modport sink (input valid, input median_doubled, output ready);
endinterface

[hw/rtl/swm_ram.sv]
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the contents before a write to the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: keeps, takes a neighbor, or takes the sample.
// ----------------------------------------------------------------------------
module swm_cell (
	input  logic             clk,
	input  swm_pkg::swm_upd_t upd,
	input  logic             own_valid,
	input  logic             left_valid,
	input  logic             right_valid,
	input  swm_pkg::smp_t    left_val,
	input  swm_pkg::smp_t    right_val,
	output swm_pkg::smp_t    val
);
	import swm_pkg::*;

	smp_t val_q;
	smp_t nxt;
	logic keep_hi, shift_up, take_up;
	logic keep_lo, shift_dn, take_dn;

	// neighbor compares; a slot past the fill count reads as +infinity
	always_comb begin
		keep_hi  = upd.full && left_valid && ($signed(left_val) >= $signed(upd.old));
		shift_up = left_valid && ($signed(left_val) > $signed(upd.smp));
		take_up  = !own_valid || ($signed(val_q) > $signed(upd.smp));
		keep_lo  = right_valid && ($signed(right_val) <= $signed(upd.old));
		shift_dn = right_valid && ($signed(right_val) <= $signed(upd.smp));
		take_dn  = $signed(val_q) <= $signed(upd.smp);
	end

	// next value: removal point above the insert point shifts up, below it down
	always_comb begin
		nxt = val_q;
		if (upd.up) begin
			if (keep_hi) begin
				nxt = val_q;
			end else if (shift_up) begin
				nxt = left_val;
			end else if (take_up) begin
				nxt = upd.smp;
			end
		end else begin
			if (keep_lo) begin
				nxt = val_q;
			end else if (shift_dn) begin
				nxt = right_val;
			end else if (take_dn) begin
				nxt = upd.smp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule

[hw/rtl/swm_sorter.sv]
// ----------------------------------------------------------------------------
// swm_sorter
// Row of sorted cells plus the middle-pair tap that forms the doubled median.
// ----------------------------------------------------------------------------
module swm_sorter (
	input  logic              clk,
	input  swm_pkg::swm_upd_t upd,
	input  swm_pkg::cnt_t     count,
	input  swm_pkg::idx_t     lo_idx,
	input  swm_pkg::idx_t     hi_idx,
	output swm_pkg::sum_t     median_doubled
);
	import swm_pkg::*;

	smp_t            val [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] valid;
	smp_t            lo_val, hi_val;

	// slots below the count hold live samples
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			valid[i] = CNT_W'(i) < count;
		end
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		smp_t lv, rv;
		logic lvld, rvld;

		if (i == 0) begin : g_first
			assign lv   = '0;
			assign lvld = 1'b0;
		end else begin : g_left
			assign lv   = val[i-1];
			assign lvld = valid[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_last
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_right
			assign rv   = val[i+1];
			assign rvld = valid[i+1];
		end

		swm_cell u_cell (
			.clk         (clk),
			.upd         (upd),
			.own_valid   (valid[i]),
			.left_valid  (lvld),
			.right_valid (rvld),
			.left_val    (lv),
			.right_val   (rv),
			.val         (val[i])
		);
	end

	// middle pair; both taps coincide for an odd window
	assign lo_val = val[lo_idx];
	assign hi_val = val[hi_idx];
	assign median_doubled = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};

endmodule

[hw/rtl/sliding_window_median.sv]
// ----------------------------------------------------------------------------
// sliding_window_median
// Streaming median filter over the last window_size signed samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock and, once the window holds window_size samples,
// returns twice the window median per sample (sum of the two middle values
// for an even window). A result is formed in order after its sample is
// accepted: the arrival ring RAM is written and the leaving sample read at
// acceptance, then the row of 64 sorted cells updates, and last the middle
// pair is summed into the output register. The input stalls only when a
// finished result is blocked behind an output register that is not being
// drained. Writing window_size (or a beat with frame_start set) empties the
// window; no clearing pass is needed after reset.
// Writes to window_size are expected only while no sample is in flight.
// ----------------------------------------------------------------------------
module sliding_window_median (
	input  logic                clk,
	input  logic                arst_n,
	swm_in_if.sink              samples,
	swm_out_if.source           medians,
	input  logic                cfg_we,
	input  logic [swm_pkg::CFG_W-1:0] cfg_data
);
	import swm_pkg::*;

	// window configuration, decoded at write time
	cnt_t k_q;
	idx_t lo_q, hi_q;
	cnt_t k_wr;

	// window bookkeeping
	cnt_t fill_q;
	idx_t oldest_q;
	cnt_t fill_eff, pos_sum, oldest_inc;
	idx_t oldest_eff, ram_addr;
	logic full_now, emit_now;

	// pipeline
	logic adv, accept, blk2;
	logic s1_valid_q, full_s1, emit_s1;
	cnt_t n_s1;
	smp_t smp_s1;
	logic s2_valid_q;
	logic out_valid_q;
	sum_t median_q;

	smp_t old_smp;
	swm_upd_t upd;
	sum_t median_sum;

	// stall only when a finished result cannot move into the output register
	assign blk2   = s2_valid_q && out_valid_q && !medians.ready;
	assign adv    = !blk2;
	assign accept = samples.valid && adv;
	assign samples.ready = adv;

	// effective fill and ring position for the incoming beat
	always_comb begin
		fill_eff   = fill_q;
		oldest_eff = oldest_q;
		if (samples.frame_start || (fill_q > k_q)) begin
			fill_eff   = '0;
			oldest_eff = '0;
		end
		if (CNT_W'(oldest_eff) >= k_q) begin
			oldest_eff = '0;
		end
		full_now = fill_eff >= k_q;
		emit_now = full_now || ((fill_eff + CNT_W'(1)) == k_q);
		pos_sum  = CNT_W'(oldest_eff) + fill_eff;
		if (pos_sum >= k_q) begin
			pos_sum = pos_sum - k_q;
		end
		oldest_inc = CNT_W'(oldest_eff) + CNT_W'(1);
		if (oldest_inc == k_q) begin
			oldest_inc = '0;
		end
		ram_addr = full_now ? oldest_eff : pos_sum[IDX_W-1:0];
	end

	assign k_wr = eff_window(cfg_data);

	// configuration and window counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= eff_window(CFG_W'(WINDOW_RESET));
			lo_q     <= IDX_W'((eff_window(CFG_W'(WINDOW_RESET)) - CNT_W'(1)) >> 1);
			hi_q     <= IDX_W'(eff_window(CFG_W'(WINDOW_RESET)) >> 1);
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (cfg_we) begin
			k_q      <= k_wr;
			lo_q     <= IDX_W'((k_wr - CNT_W'(1)) >> 1);
			hi_q     <= IDX_W'(k_wr >> 1);
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (accept) begin
			if (full_now) begin
				fill_q   <= fill_eff;
				oldest_q <= oldest_inc[IDX_W-1:0];
			end else begin
				fill_q   <= fill_eff + CNT_W'(1);
				oldest_q <= oldest_eff;
			end
		end
	end

	// arrival ring: the leaving sample is read as the new one replaces it
	swm_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.re    (accept && full_now),
		.addr  (ram_addr),
		.wdata (samples.sample),
		.rdata (old_smp)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			full_s1    <= 1'b0;
			emit_s1    <= 1'b0;
			n_s1       <= '0;
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= accept;
			full_s1    <= full_now;
			emit_s1    <= emit_now;
			n_s1       <= fill_eff;
			s2_valid_q <= s1_valid_q && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1 <= samples.sample;
		end
	end

	// cell row command
	always_comb begin
		upd.en   = adv && s1_valid_q;
		upd.full = full_s1;
		upd.up   = !full_s1 || ($signed(smp_s1) < $signed(old_smp));
		upd.smp  = smp_s1;
		upd.old  = old_smp;
	end

	swm_sorter u_sorter (
		.clk            (clk),
		.upd            (upd),
		.count          (n_s1),
		.lo_idx         (lo_q),
		.hi_idx         (hi_q),
		.median_doubled (median_sum)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || medians.ready) begin
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if ((!out_valid_q || medians.ready) && s2_valid_q) begin
			median_q <= median_sum;
		end
	end

	assign medians.valid          = out_valid_q;
	assign medians.median_doubled = median_q;

endmodule

[hw/rtl/swm_checker.sv]
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks for the sliding window median filter, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input swm_pkg::sum_t       out_data
);
	import swm_pkg::*;

	// a stalled result stays offered and unchanged
	`SWM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SWM_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))

	// input backpressure only comes from a blocked output beat
	`SWM_ASSERT_NOW(a_in_stall, clk, arst_n, !in_ready, out_valid && !out_ready)

endmodule

bind sliding_window_median swm_checker u_swm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (samples.ready),
	.out_valid (medians.valid),
	.out_ready (medians.ready),
	.out_data  (medians.median_doubled)
);

[test/sliding_window_median_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Self-checking bench for the streaming window median filter.
// ----------------------------------------------------------------------------
// A short directed table opens the run. It covers the sample extremes,
// restarts with frame_start, and duplicates leaving a full window. Random
// phases follow, each one after a window_size write: zero, one, even and odd
// sizes, full size and sizes above it. A local sorted-window model predicts
// every median beat, and each beat is checked in order. Both sides idle in
// random bursts except in the last phase.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
	import swm_pkg::*;

	localparam smp_t S_MAX      = 32'sh7FFFFFFF;
	localparam smp_t S_MIN      = 32'sh80000000;
	localparam sum_t MED_TOP    = 33'sh0FFFFFFFE;
	localparam sum_t MED_BOTTOM = 33'sh100000000;

	localparam int SETTLE_CYCLES  = 6;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		bit   fs;
		smp_t smp;
		bit   typed;  // want holds the median beat typed in by hand
		sum_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_t cfg_data;

	swm_in_if  samples_if ();
	swm_out_if medians_if ();

	sliding_window_median DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_if),
		.medians  (medians_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// medians still due, oldest first
	sum_t median_q [$];

	// window model: register, arrival ring, sorted copy, fill and oldest index
	cfg_t        win_reg;
	smp_t        ring [MAX_WINDOW];
	smp_t        ordered [MAX_WINDOW];
	int unsigned held;
	int unsigned head;

	int unsigned mismatches = 0;
	int unsigned beat_no = 0;
	int unsigned gap_odds = 0;
	int unsigned stall_odds = 0;

	// opening table, window size 3 after reset
	stim_row_t opening_rows [24] = '{
		'{1'b1, S_MAX, 1'b0, '0},
		'{1'b0, S_MAX, 1'b0, '0},
		'{1'b0, S_MAX, 1'b1, MED_TOP},
		'{1'b0, S_MIN, 1'b1, MED_TOP},
		'{1'b0, S_MIN, 1'b1, MED_BOTTOM},
		'{1'b0, S_MIN, 1'b1, MED_BOTTOM},
		'{1'b0, 0,     1'b1, MED_BOTTOM},
		'{1'b0, 5,     1'b1, '0},
		'{1'b0, 5,     1'b0, '0},
		'{1'b0, 5,     1'b0, '0},
		// restart on a full window, then duplicates leave
		'{1'b1, -1,    1'b0, '0},
		'{1'b0, 3,     1'b0, '0},
		'{1'b0, 3,     1'b0, '0},
		'{1'b0, -7,    1'b0, '0},
		'{1'b0, 3,     1'b0, '0},
		// restart while still filling
		'{1'b1, 10,    1'b0, '0},
		'{1'b0, 20,    1'b0, '0},
		'{1'b1, 30,    1'b0, '0},
		'{1'b0, 40,    1'b0, '0},
		'{1'b0, 50,    1'b0, '0},
		'{1'b0, -9,    1'b0, '0},
		'{1'b0, 2,     1'b0, '0},
		// partial fill, dropped by the rewrite that follows
		'{1'b1, 11,    1'b0, '0},
		'{1'b0, 12,    1'b0, '0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// window length for a register value
	function automatic int unsigned span_of(cfg_t w);
		if (w == '0) return 1;
		if (w > MAX_WINDOW) return MAX_WINDOW;
		return w;
	endfunction

	// drop one copy of v from the first n sorted entries
	task automatic sorted_drop(input smp_t v, input int unsigned n);
		int unsigned i;
		i = 0;
		while (i < n && ordered[i] != v) i++;
		if (i < n) begin
			while (i + 1 < n) begin
				ordered[i] = ordered[i + 1];
				i++;
			end
		end
	endtask

	// insert v into the first n sorted entries
	task automatic sorted_put(input smp_t v, input int unsigned n);
		int unsigned i;
		i = n;
		while (i > 0 && ordered[i - 1] > v) begin
			ordered[i] = ordered[i - 1];
			i--;
		end
		ordered[i] = v;
	endtask

	// one accepted beat through the window model
	task automatic predict_median(input bit fs, input smp_t s,
			output bit emits, output sum_t med);
		int unsigned k;
		k = span_of(win_reg);
		emits = 1'b0;
		med = '0;
		if (fs || held > k) begin
			held = 0;
			head = 0;
		end
		if (head >= k) head = 0;
		if (held < k) begin
			ring[(head + held) % k] = s;
			sorted_put(s, held);
			held++;
			if (held < k) return;
		end else begin
			sorted_drop(ring[head], k);
			sorted_put(s, k - 1);
			ring[head] = s;
			head = (head + 1) % k;
		end
		emits = 1'b1;
		if (k % 2 == 1) begin
			med = {ordered[(k - 1) / 2], 1'b0};
		end else begin
			med = sum_t'(ordered[k / 2 - 1]) + sum_t'(ordered[k / 2]);
		end
	endtask

	// chance of starting an idle burst: 0 means none
	function automatic int unsigned pick_odds();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			2: return 6;
			default: return 15;
		endcase
	endfunction

	// extremes, a crowded band near zero for duplicates, and full-range values
	function automatic smp_t pick_sample();
		case ($urandom_range(0, 11)) inside
			0: return S_MAX;
			1: return S_MIN;
			2: return S_MAX - smp_t'($urandom_range(0, 2));
			3: return S_MIN + smp_t'($urandom_range(0, 2));
			[4:6]: return smp_t'($urandom_range(0, 6)) - 3;
			default: return smp_t'($urandom());
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_sample(input bit fs, input smp_t smp,
			input bit typed, input sum_t want);
		bit   emits;
		sum_t med;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		samples_if.valid       <= 1'b1;
		samples_if.frame_start <= fs;
		samples_if.sample      <= smp;
		do @(posedge clk); while (!samples_if.ready);
		predict_median(fs, smp, emits, med);
		if (emits) median_q = {median_q, (typed ? want : med)};
		@(negedge clk);
	endtask

	// all medians in, then let fill-only beats clear the pipeline
	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		while (median_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_window(input cfg_t w);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		win_reg = w;
		held = 0;
		head = 0;
	endtask

	task automatic flag_mismatch(input string what, input sum_t want, input sum_t got);
		if (mismatches < 10) begin
			$display("median beat %0d: %s, expected %0d, got %0d", beat_no, what, want, got);
		end
		mismatches++;
	endtask

	// compare each median beat with the oldest one due
	always @(posedge clk) begin : check_medians
		sum_t want;
		if (arst_n && medians_if.valid && medians_if.ready) begin
			if (median_q.size() == 0) begin
				flag_mismatch("no median due", '0, medians_if.median_doubled);
			end else begin
				want = median_q.pop_front();
				if (medians_if.median_doubled !== want) begin
					flag_mismatch("wrong median", want, medians_if.median_doubled);
				end
			end
			beat_no++;
		end
	end

	// output stalls in random bursts
	initial begin : drain_medians
		int unsigned hold;
		hold = 0;
		medians_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				hold = $urandom_range(1, 10);
			end
			if (hold != 0) begin
				medians_if.ready <= 1'b0;
				hold--;
			end else begin
				medians_if.ready <= 1'b1;
			end
		end
	end

	// end the run when no beat moves on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (samples_if.valid && samples_if.ready) ||
					(medians_if.valid && medians_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("sliding_window_median: mismatch");
		$finish;
	end

	initial begin : stimulus
		cfg_t        plan [$];
		int unsigned k;
		int unsigned count;
		int unsigned fs_odds;
		samples_if.valid       = 1'b0;
		samples_if.frame_start = 1'b0;
		samples_if.sample      = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		arst_n   = 1'b0;
		win_reg  = cfg_t'(WINDOW_RESET);
		held = 0;
		head = 0;
		gap_odds   = pick_odds();
		stall_odds = pick_odds();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening
		foreach (opening_rows[i]) begin
			send_sample(opening_rows[i].fs, opening_rows[i].smp,
				opening_rows[i].typed, opening_rows[i].want);
		end

		// random phases; the first rewrites the reset value
		plan = '{7'd3, 7'd1, 7'd0, 7'd2, 7'd64, 7'd127, 7'd4, 7'd65};
		plan = {plan, cfg_t'($urandom_range(5, 16))};
		plan = {plan, cfg_t'($urandom_range(17, 40))};
		plan = {plan, 7'd7};
		foreach (plan[p]) begin
			write_window(plan[p]);
			if (p == plan.size() - 1) begin
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				gap_odds   = pick_odds();
				stall_odds = pick_odds();
			end
			k       = span_of(plan[p]);
			count   = 30 + k;
			fs_odds = (k >= 32) ? 80 : 25;
			repeat (count) begin
				send_sample($urandom_range(1, fs_odds) == 1, pick_sample(), 1'b0, '0);
			end
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("sliding_window_median: match");
		end else begin
			$display("sliding_window_median: mismatch");
		end
		$finish;
	end

endmodule

[sliding_window_median.f]
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_ram.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_sorter.sv
hw/rtl/sliding_window_median.sv
hw/rtl/swm_checker.sv
test/sliding_window_median_tb.sv
